// ----- sv/tmt_pkg.sv -----
`default_nettype none

package tmt_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 8;
  localparam int unsigned SLOT_CMP_W    = 6;
  localparam logic [15:0] PERIOD_CAP    = 16'hfff0;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_STOP    = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] reload;
    logic [31:0] remaining;
  } slot_ent_t;

endpackage

`default_nettype wire

// ----- sv/tickless_multi_timer.sv -----
`default_nettype none

// channel  | ports                                           | transfer
// ---------+-------------------------------------------------+-------------------------------
// command  | start, busy, in_func, in_slot, in_interval_ticks | start high while busy low
//          | in_repeat_mode, in_elapsed                       |
// result   | out_strobe, out_fired, out_fired_slot,           | every cycle with out_strobe
//          | out_deferred, out_last, out_counter_enable,      |
//          | out_next_period                                  |
//
// aging command: busy through the prime read, one read-modify-write per slot and the
// final result; the final result is on the ports in the first cycle with busy low, when
// the next transfer can already be taken. restart or stop of an inactive slot skips the
// walk and is busy only for the final result.
// synchronous active-low reset clears active bits, period and sequencer; an inactive
// slot's memory entry is never used, so the memory is not cleared. receiver never stalls.

module tickless_multi_timer #(
  parameter int unsigned NUM_SLOTS = tmt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [2:0]  in_slot,
  input  wire logic [31:0] in_interval_ticks,
  input  wire logic [1:0]  in_repeat_mode,
  input  wire logic [15:0] in_elapsed,
  output logic             out_strobe,
  output logic             out_fired,
  output logic [2:0]       out_fired_slot,
  output logic             out_deferred,
  output logic             out_last,
  output logic             out_counter_enable,
  output logic [15:0]      out_next_period
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = tmt_pkg::SLOT_CMP_W;

  tmt_pkg::state_t state_r, state_nxt;

  tmt_pkg::slot_ent_t mem [NUM_SLOTS];
  tmt_pkg::slot_ent_t rd_data_r;
  tmt_pkg::slot_ent_t wr_data;
  logic [SW-1:0]      rd_addr;
  logic               rd_en;

  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [15:0]          cur_period_r, cur_period_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [15:0]          min_r, min_nxt;
  logic                 any_r, any_nxt;

  // command fields held for the walk
  logic [1:0]    func_r;
  logic [SW-1:0] slot_r;
  logic [31:0]   interval_r;
  logic [1:0]    mode_r;
  logic [15:0]   amount_r;

  logic          accept;
  logic          slot_ok;
  logic [SW-1:0] in_idx;
  logic          op_go;
  logic          last_step;

  // per-slot step
  logic        act;
  logic [31:0] rem_aged;
  logic        fire;
  logic [31:0] rem_new;
  logic [31:0] reload_new;
  logic [1:0]  mode_new;
  logic        act_new;
  logic        sel;

  logic        out_strobe_r, out_strobe_nxt;
  logic        out_fired_r, out_fired_nxt;
  logic [2:0]  out_slot_r, out_slot_nxt;
  logic        out_def_r, out_def_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_en_r, out_en_nxt;
  logic [15:0] out_per_r, out_per_nxt;

  assign accept  = start && !busy;
  assign slot_ok = CW'(in_slot) < CW'(NUM_SLOTS);
  assign in_idx  = SW'(in_slot);
  assign op_go   = (in_func == tmt_pkg::FUNC_TICK) ||
                   (slot_ok && ((in_func == tmt_pkg::FUNC_START) || active_r[in_idx]));
  assign last_step = (idx_r == SW'(NUM_SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = op_go ? tmt_pkg::ST_FETCH : tmt_pkg::ST_DONE;
        end
      end
      tmt_pkg::ST_FETCH: state_nxt = tmt_pkg::ST_WALK;
      tmt_pkg::ST_WALK: begin
        if (last_step) begin
          state_nxt = tmt_pkg::ST_DONE;
        end
      end
      tmt_pkg::ST_DONE: state_nxt = tmt_pkg::ST_IDLE;
      default: state_nxt = tmt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      tmt_pkg::ST_IDLE:  busy = 1'b0;
      tmt_pkg::ST_FETCH: rd_en = 1'b1;
      tmt_pkg::ST_WALK: begin
        rd_en   = !last_step;
        rd_addr = idx_r + 1'b1;
      end
      tmt_pkg::ST_DONE:  busy = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // age one slot, then apply the command if it addresses this slot
  always_comb begin
    act      = active_r[idx_r];
    rem_aged = (rd_data_r.remaining <= 32'(amount_r)) ? 32'd0
                                                     : rd_data_r.remaining - 32'(amount_r);
    fire     = act && (rem_aged == 32'd0);
    rem_new    = rem_aged;
    reload_new = rd_data_r.reload;
    mode_new   = rd_data_r.mode;
    act_new    = act;
    if (fire) begin
      if (rd_data_r.mode[0]) begin
        rem_new = rd_data_r.reload;
      end else begin
        act_new = 1'b0;
      end
    end
    sel = (idx_r == slot_r);
    if (sel) begin
      case (func_r)
        tmt_pkg::FUNC_START: begin
          rem_new    = interval_r;
          reload_new = interval_r;
          mode_new   = mode_r;
          act_new    = 1'b1;
        end
        tmt_pkg::FUNC_RESTART: begin
          if (act_new) begin
            rem_new = rd_data_r.reload;
          end
        end
        tmt_pkg::FUNC_STOP: act_new = 1'b0;
        default: ;
      endcase
    end
    wr_data = '{mode: mode_new, reload: reload_new, remaining: rem_new};
  end

  // walk bookkeeping and result register
  always_comb begin
    active_nxt     = active_r;
    cur_period_nxt = cur_period_r;
    idx_nxt        = idx_r;
    min_nxt        = min_r;
    any_nxt        = any_r;
    out_strobe_nxt = 1'b0;
    out_fired_nxt  = 1'b0;
    out_slot_nxt   = '0;
    out_def_nxt    = 1'b0;
    out_last_nxt   = 1'b0;
    out_en_nxt     = 1'b0;
    out_per_nxt    = '0;
    unique case (state_r)
      tmt_pkg::ST_IDLE: begin
        idx_nxt = '0;
        min_nxt = tmt_pkg::PERIOD_CAP;
        any_nxt = 1'b0;
      end
      tmt_pkg::ST_FETCH: ;
      tmt_pkg::ST_WALK: begin
        active_nxt[idx_r] = act_new;
        if (act_new) begin
          any_nxt = 1'b1;
          if (rem_new < 32'(min_r)) begin
            min_nxt = rem_new[15:0];
          end
        end
        if (fire) begin
          out_strobe_nxt = 1'b1;
          out_fired_nxt  = 1'b1;
          out_slot_nxt   = 3'(idx_r);
          out_def_nxt    = rd_data_r.mode[1];
        end
        if (last_step) begin
          cur_period_nxt = any_nxt ? min_nxt : 16'd0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      tmt_pkg::ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_last_nxt   = 1'b1;
        out_en_nxt     = |active_r;
        out_per_nxt    = (|active_r) ? cur_period_r : 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tmt_pkg::ST_IDLE;
      active_r     <= '0;
      cur_period_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      cur_period_r <= cur_period_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    min_r      <= min_nxt;
    any_r      <= any_nxt;
    out_fired_r <= out_fired_nxt;
    out_slot_r <= out_slot_nxt;
    out_def_r  <= out_def_nxt;
    out_last_r <= out_last_nxt;
    out_en_r   <= out_en_nxt;
    out_per_r  <= out_per_nxt;
    if (accept) begin
      func_r     <= in_func;
      slot_r     <= in_idx;
      interval_r <= in_interval_ticks;
      mode_r     <= in_repeat_mode;
      amount_r   <= (in_func == tmt_pkg::FUNC_TICK) ? cur_period_r : in_elapsed;
    end
  end

  // slot memory: one read and one write port, each slot touched once per walk
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (state_r == tmt_pkg::ST_WALK) begin
      mem[idx_r] <= wr_data;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_fired          = out_fired_r;
  assign out_fired_slot     = out_slot_r;
  assign out_deferred       = out_def_r;
  assign out_last           = out_last_r;
  assign out_counter_enable = out_en_r;
  assign out_next_period    = out_per_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after command transfer");

  a_fire_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_fired) |-> busy)
    else $error("expiry shown outside a walk");

  a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> (!out_fired && !busy))
    else $error("final result malformed or early");

  a_period_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |->
      ((out_next_period <= tmt_pkg::PERIOD_CAP) &&
       (out_counter_enable || (out_next_period == 16'd0))))
    else $error("period out of range");
`endif

endmodule

`default_nettype wire

// ----- test/tmt_checker.sv -----
`default_nettype none

module tmt_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [2:0]  in_slot,
  input  wire logic [31:0] in_interval_ticks,
  input  wire logic [1:0]  in_repeat_mode,
  input  wire logic [15:0] in_elapsed,
  input  wire logic        out_strobe,
  input  wire logic        out_fired,
  input  wire logic [2:0]  out_fired_slot,
  input  wire logic        out_deferred,
  input  wire logic        out_last,
  input  wire logic        out_counter_enable,
  input  wire logic [15:0] out_next_period,
  output int               error_count,
  output int               pending_count
);

  localparam int SLOTS = int'(tmt_pkg::NUM_SLOTS_DEF);

  typedef struct packed {
    logic        fired;
    logic [2:0]  slot;
    logic        deferred;
    logic        last;
    logic        enable;
    logic [15:0] period;
  } timer_result_t;

  timer_result_t expected_results[$];
  timer_result_t want;

  logic [31:0] remain_cnt [SLOTS];
  logic [31:0] reload_cnt [SLOTS];
  logic [1:0]  slot_mode  [SLOTS];
  logic        slot_on    [SLOTS];
  logic [15:0] period_now;

  // age every running slot, queue an expiry for each one that hits zero
  function automatic void age_timers(logic [31:0] amount);
    timer_result_t r;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_on[i]) begin
        remain_cnt[i] = (remain_cnt[i] <= amount) ? 32'd0 : remain_cnt[i] - amount;
        if (remain_cnt[i] == 32'd0) begin
          r = '0;
          r.fired = 1'b1;
          r.slot = i[2:0];
          r.deferred = slot_mode[i][1];
          expected_results.push_back(r);
          if (slot_mode[i][0])
            remain_cnt[i] = reload_cnt[i];
          else
            slot_on[i] = 1'b0;
        end
      end
    end
  endfunction

  function automatic logic any_running();
    logic any;
    any = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_on[i]) any = 1'b1;
    return any;
  endfunction

  function automatic void refresh_period();
    logic [31:0] best;
    best = {16'd0, tmt_pkg::PERIOD_CAP};
    for (int i = 0; i < SLOTS; i++)
      if (slot_on[i] && remain_cnt[i] < best) best = remain_cnt[i];
    period_now = any_running() ? best[15:0] : 16'd0;
  endfunction

  function automatic void predict_command(logic [1:0] func, logic [2:0] slot,
                                          logic [31:0] interval, logic [1:0] mode,
                                          logic [15:0] elapsed);
    timer_result_t r;
    case (func)
      tmt_pkg::FUNC_TICK: begin
        age_timers({16'd0, period_now});
        refresh_period();
      end
      tmt_pkg::FUNC_START: begin
        age_timers({16'd0, elapsed});
        reload_cnt[slot] = interval;
        remain_cnt[slot] = interval;
        slot_mode[slot] = mode;
        slot_on[slot] = 1'b1;
        refresh_period();
      end
      default: begin
        // restart or stop of an idle slot leaves everything alone
        if (slot_on[slot]) begin
          age_timers({16'd0, elapsed});
          if (func == tmt_pkg::FUNC_RESTART) begin
            if (slot_on[slot]) remain_cnt[slot] = reload_cnt[slot];
          end else begin
            slot_on[slot] = 1'b0;
          end
          refresh_period();
        end
      end
    endcase
    r = '0;
    r.last = 1'b1;
    r.enable = any_running();
    r.period = r.enable ? period_now : 16'd0;
    expected_results.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        remain_cnt[i] = '0;
        reload_cnt[i] = '0;
        slot_mode[i] = '0;
        slot_on[i] = 1'b0;
      end
      period_now = '0;
      expected_results.delete();
      error_count = 0;
    end else begin
      // results first so a transfer in the same cycle cannot mask a stray result
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: fired %0b slot %0d last %0b period 0x%0h",
                 out_fired, out_fired_slot, out_last, out_next_period);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("fired", 32'(want.fired), 32'(out_fired));
          check_field("fired_slot", 32'(want.slot), 32'(out_fired_slot));
          check_field("deferred", 32'(want.deferred), 32'(out_deferred));
          check_field("last", 32'(want.last), 32'(out_last));
          check_field("counter_enable", 32'(want.enable), 32'(out_counter_enable));
          check_field("next_period", 32'(want.period), 32'(out_next_period));
        end
      end
      if (start && !busy)
        predict_command(in_func, in_slot, in_interval_ticks, in_repeat_mode, in_elapsed);
    end
    pending_count = expected_results.size();
  end

endmodule

`default_nettype wire

// ----- test/tb_tickless_multi_timer.sv -----
`default_nettype none

module tb_tickless_multi_timer;

  localparam logic [1:0] ONE_SHOT   = 2'b00;
  localparam logic [1:0] CONTINUOUS = 2'b01;
  localparam logic [1:0] RELAXED    = 2'b10;
  localparam int ITEMS_PER_PHASE = 134;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SLOTS           = int'(tmt_pkg::NUM_SLOTS_DEF);

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [2:0]  in_slot;
  logic [31:0] in_interval_ticks;
  logic [1:0]  in_repeat_mode;
  logic [15:0] in_elapsed;
  logic        out_strobe;
  logic        out_fired;
  logic [2:0]  out_fired_slot;
  logic        out_deferred;
  logic        out_last;
  logic        out_counter_enable;
  logic [15:0] out_next_period;
  int          error_count;
  int          pending_count;
  int          cycle_cnt;

  tickless_multi_timer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_slot            (in_slot),
    .in_interval_ticks  (in_interval_ticks),
    .in_repeat_mode     (in_repeat_mode),
    .in_elapsed         (in_elapsed),
    .out_strobe         (out_strobe),
    .out_fired          (out_fired),
    .out_fired_slot     (out_fired_slot),
    .out_deferred       (out_deferred),
    .out_last           (out_last),
    .out_counter_enable (out_counter_enable),
    .out_next_period    (out_next_period)
  );

  tmt_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_slot            (in_slot),
    .in_interval_ticks  (in_interval_ticks),
    .in_repeat_mode     (in_repeat_mode),
    .in_elapsed         (in_elapsed),
    .out_strobe         (out_strobe),
    .out_fired          (out_fired),
    .out_fired_slot     (out_fired_slot),
    .out_deferred       (out_deferred),
    .out_last           (out_last),
    .out_counter_enable (out_counter_enable),
    .out_next_period    (out_next_period),
    .error_count        (error_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic issue(input logic [1:0] func, input logic [2:0] slot,
                       input logic [31:0] interval, input logic [1:0] mode,
                       input logic [15:0] elapsed);
    start <= 1'b1;
    in_func <= func;
    in_slot <= slot;
    in_interval_ticks <= interval;
    in_repeat_mode <= mode;
    in_elapsed <= elapsed;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic int sender_gap(input int pct);
    int n;
    n = 0;
    while (n < 20 && $urandom_range(0, 99) < pct) n++;
    return n;
  endfunction

  // mostly short intervals and small elapsed counts so slots actually expire
  task automatic send_random();
    int          pick;
    logic [1:0]  func;
    logic [31:0] interval;
    logic [15:0] elapsed;
    pick = $urandom_range(0, 99);
    if (pick < 35)      func = tmt_pkg::FUNC_START;
    else if (pick < 50) func = tmt_pkg::FUNC_RESTART;
    else if (pick < 65) func = tmt_pkg::FUNC_STOP;
    else                func = tmt_pkg::FUNC_TICK;
    pick = $urandom_range(0, 99);
    if (pick < 4)       interval = 32'd0;
    else if (pick < 14) interval = $urandom;
    else if (pick < 24) interval = $urandom_range(1, 70000);
    else                interval = $urandom_range(1, 60);
    if ($urandom_range(0, 99) < 10) elapsed = 16'($urandom_range(0, 65535));
    else                            elapsed = 16'($urandom_range(0, 30));
    issue(func, 3'($urandom_range(0, 7)), interval, 2'($urandom_range(0, 3)), elapsed);
  endtask

  initial begin
    int pct;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = tmt_pkg::FUNC_START;
    in_slot = '0;
    in_interval_ticks = '0;
    in_repeat_mode = '0;
    in_elapsed = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // nothing running: tick, restart and stop change nothing
    issue(tmt_pkg::FUNC_TICK, 3'd0, 32'd0, ONE_SHOT, 16'd0);
    issue(tmt_pkg::FUNC_RESTART, 3'd3, 32'd9, ONE_SHOT, 16'd5);
    issue(tmt_pkg::FUNC_STOP, 3'd5, 32'd9, ONE_SHOT, 16'd5);
    issue(tmt_pkg::FUNC_START, 3'd0, 32'd1, ONE_SHOT, 16'd0);
    issue(tmt_pkg::FUNC_TICK, 3'd0, 32'd0, ONE_SHOT, 16'd0);
    // huge interval caps the period
    issue(tmt_pkg::FUNC_START, 3'd7, 32'hffff_ffff, CONTINUOUS | RELAXED, 16'hfff0);
    // zero interval fires at every aging
    issue(tmt_pkg::FUNC_START, 3'd1, 32'd0, CONTINUOUS, 16'd0);
    issue(tmt_pkg::FUNC_TICK, 3'd0, 32'd0, ONE_SHOT, 16'd0);
    // start of a running slot reloads it after aging
    issue(tmt_pkg::FUNC_START, 3'd1, 32'd5, RELAXED, 16'd3);
    issue(tmt_pkg::FUNC_RESTART, 3'd7, 32'd0, ONE_SHOT, 16'hffff);
    issue(tmt_pkg::FUNC_START, 3'd2, 32'd3, ONE_SHOT, 16'd0);
    issue(tmt_pkg::FUNC_START, 3'd3, 32'd100, CONTINUOUS, 16'd0);
    issue(tmt_pkg::FUNC_START, 3'd4, 32'h0001_0000, RELAXED, 16'd0);
    issue(tmt_pkg::FUNC_STOP, 3'd4, 32'd0, ONE_SHOT, 16'd2);
    issue(tmt_pkg::FUNC_TICK, 3'd0, 32'd0, ONE_SHOT, 16'd0);
    // one-shot fires during the restart's aging, so the restart is void
    issue(tmt_pkg::FUNC_START, 3'd5, 32'd2, ONE_SHOT, 16'd0);
    issue(tmt_pkg::FUNC_RESTART, 3'd5, 32'd0, ONE_SHOT, 16'd10);
    // every slot expiring on the same tick
    for (int s = 0; s < SLOTS; s++)
      issue(tmt_pkg::FUNC_START, 3'(s), 32'd1, CONTINUOUS, 16'd0);
    issue(tmt_pkg::FUNC_TICK, 3'd0, 32'd0, ONE_SHOT, 16'd0);
    wait_all_results();

    for (int phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_random();
        idle_for(sender_gap(pct));
      end
      wait_all_results();
    end

    repeat (SLOTS + 4) @(negedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
